// ===== rtl/core/ppi_pkg.sv =====
// Package for the planar pose integrator: widths, opcodes, angle table and the
// multiply-accumulate command type shared by the sequencer and the MAC.
// No dependencies.
package ppi_pkg;

	// Default number of CORDIC iterations (legal range 8 to 30)
	localparam int PPI_CORDIC_STEPS = 16;

	// Field widths
	localparam int VEL_W   = 16;
	localparam int RATE_W  = 24;
	localparam int DT_W    = 24;
	localparam int POSE_W  = 32;

	// Datapath widths: CORDIC x/y/z, MAC operands and accumulator
	localparam int CRD_W   = 34;
	localparam int MAC_A_W = 34;
	localparam int MAC_B_W = 24;
	localparam int ACC_W   = MAC_A_W + MAC_B_W;

	// CORDIC start vector: gain 0.60725 in Q30
	localparam logic signed [CRD_W-1:0] GAIN_Q30 = CRD_W'(652032874);

	// Angle table index width (30 entries)
	localparam int ATAN_IDX_W = 5;

	// Input beat opcodes
	typedef enum logic {
		OP_INTEGRATE = 1'b0,
		OP_LOAD      = 1'b1
	} op_t;

	// Multiply-accumulate command
	typedef struct packed {
		logic                      en;
		logic                      clr;
		logic                      neg;
		logic signed [MAC_A_W-1:0] a;
		logic signed [MAC_B_W-1:0] b;
	} mac_cmd_t;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [29:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0:  v = 30'd536870912;
			5'd1:  v = 30'd316933406;
			5'd2:  v = 30'd167458907;
			5'd3:  v = 30'd85004756;
			5'd4:  v = 30'd42667331;
			5'd5:  v = 30'd21354465;
			5'd6:  v = 30'd10679838;
			5'd7:  v = 30'd5340245;
			5'd8:  v = 30'd2670163;
			5'd9:  v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			5'd24: v = 30'd41;
			5'd25: v = 30'd20;
			5'd26: v = 30'd10;
			5'd27: v = 30'd5;
			5'd28: v = 30'd3;
			5'd29: v = 30'd1;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/core/ppi_cordic.sv =====
// Iterative rotation-mode CORDIC: one micro-rotation per cycle on a shared
// add/subtract and shift unit. Depends on ppi_pkg.
module ppi_cordic
	import ppi_pkg::*;
#(
	parameter int STEPS = PPI_CORDIC_STEPS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [POSE_W-1:0]       angle,
	output logic                    done,
	output logic signed [CRD_W-1:0] cos_out,
	output logic signed [CRD_W-1:0] sin_out
);

	localparam int CNT_W = $clog2(STEPS);

	logic                    busy_q;
	logic                    done_q;
	logic                    flip_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [CRD_W-1:0] x_q, y_q, z_q;
	logic signed [CRD_W-1:0] x_sh, y_sh, atan_v;
	logic                    flip;

	// Fold the left half-plane onto the right one
	assign flip   = angle[31] ^ angle[30];
	assign x_sh   = x_q >>> cnt_q;
	assign y_sh   = y_q >>> cnt_q;
	assign atan_v = CRD_W'(atan_turn(ATAN_IDX_W'(cnt_q)));

	// Sequence the micro-rotations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Rotate towards zero residual angle
	always_ff @(posedge clk) begin
		if (start) begin
			flip_q <= flip;
			x_q    <= GAIN_Q30;
			y_q    <= '0;
			z_q    <= CRD_W'($signed({angle[31] ^ flip, angle[30:0]}));
		end else if (busy_q) begin
			if (!z_q[CRD_W-1]) begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - atan_v;
			end else begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + atan_v;
			end
		end
	end

	// Undo the half-turn fold
	assign cos_out = flip_q ? -x_q : x_q;
	assign sin_out = flip_q ? -y_q : y_q;
	assign done    = done_q;

endmodule

// ===== rtl/core/ppi_mac.sv =====
// Shared signed multiply-accumulate unit, one product per cycle.
// Depends on ppi_pkg.
module ppi_mac
	import ppi_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_cmd_t                cmd,
	output logic signed [ACC_W-1:0] acc
);

	logic signed [ACC_W-1:0] prod;
	logic signed [ACC_W-1:0] base;
	logic signed [ACC_W-1:0] acc_q;

	// Sign-extend the operands; the product itself is 34 by 24 bits
	assign prod = ACC_W'(cmd.a) * ACC_W'(cmd.b);
	assign base = cmd.clr ? '0 : acc_q;

	// Accumulate or subtract the product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.en) begin
			acc_q <= cmd.neg ? (base - prod) : (base + prod);
		end
	end

	assign acc = acc_q;

endmodule

// ===== rtl/core/planar_pose_integrator.sv =====
// Planar dead-reckoning pose integrator (x, y, heading).
// A load beat goes straight to the done state; an integrate beat runs the
// iterative CORDIC, then seven passes through the single shared
// multiply-accumulate unit, then waits in the done state for a free output.
// One beat at a time: a new beat is taken only when idle, even while a result waits.
// Reset (arst_n low, asynchronous): pose clears to zero, no result pending.
module planar_pose_integrator
	import ppi_pkg::*;
#(
	parameter int CORDIC_STEPS = PPI_CORDIC_STEPS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// vel_forward[15:0], vel_lateral[31:16], yaw_rate[55:32], time_step[79:56],
	// load_x[111:80], load_y[143:112], load_heading[175:144]
	input  logic [175:0] s_axis_tdata,
	// opcode[0]
	input  logic [0:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_x[31:0], out_y[63:32], out_heading[95:64]
	output logic [95:0]  m_axis_tdata
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_CORDIC = 4'd1;
	localparam logic [3:0] ST_M0     = 4'd2;
	localparam logic [3:0] ST_M1     = 4'd3;
	localparam logic [3:0] ST_M2     = 4'd4;
	localparam logic [3:0] ST_M3     = 4'd5;
	localparam logic [3:0] ST_M4     = 4'd6;
	localparam logic [3:0] ST_M5     = 4'd7;
	localparam logic [3:0] ST_M6     = 4'd8;
	localparam logic [3:0] ST_M7     = 4'd9;
	localparam logic [3:0] ST_DONE   = 4'd10;

	logic [3:0]                state_q;
	logic [POSE_W-1:0]         x_q, y_q, heading_q;
	logic signed [VEL_W-1:0]   vf_q, vl_q;
	logic signed [RATE_W-1:0]  yr_q;
	logic signed [DT_W-1:0]    dt_q;
	logic signed [MAC_A_W-1:0] wx_q, wy_q;
	logic                      m_valid_q;
	logic [95:0]               m_data_q;

	logic                      accept;
	logic                      cordic_start;
	logic                      cordic_done;
	logic signed [CRD_W-1:0]   cos_v, sin_v;
	mac_cmd_t                  mac_cmd;
	logic signed [ACC_W-1:0]   acc;
	logic signed [ACC_W-1:0]   acc_r14, acc_r32, acc_r4;
	logic signed [DT_W-1:0]    dt_in;
	logic                      out_free;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cordic_start  = accept && (s_axis_tuser[0] == OP_INTEGRATE);
	assign dt_in         = s_axis_tdata[79:56];
	assign out_free      = !m_valid_q || m_axis_tready;

	ppi_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cordic_start),
		.angle   (heading_q),
		.done    (cordic_done),
		.cos_out (cos_v),
		.sin_out (sin_v)
	);

	ppi_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mac_cmd),
		.acc    (acc)
	);

	// Round to nearest, ties upwards
	assign acc_r14 = (acc + ACC_W'(64'sd1 <<< 13)) >>> 14;
	assign acc_r32 = (acc + ACC_W'(64'sd1 <<< 31)) >>> 32;
	assign acc_r4  = (acc + ACC_W'(8)) >>> 4;

	// Select MAC operands for each sequencer step
	always_comb begin
		mac_cmd = '0;
		case (state_q)
			ST_M0: begin
				mac_cmd = '{en: 1'b1, clr: 1'b1, neg: 1'b0, a: cos_v, b: MAC_B_W'(vf_q)};
			end
			ST_M1: begin
				mac_cmd = '{en: 1'b1, clr: 1'b0, neg: 1'b1, a: sin_v, b: MAC_B_W'(vl_q)};
			end
			ST_M2: begin
				mac_cmd = '{en: 1'b1, clr: 1'b1, neg: 1'b0, a: sin_v, b: MAC_B_W'(vf_q)};
			end
			ST_M3: begin
				mac_cmd = '{en: 1'b1, clr: 1'b0, neg: 1'b0, a: cos_v, b: MAC_B_W'(vl_q)};
			end
			ST_M4: begin
				mac_cmd = '{en: 1'b1, clr: 1'b1, neg: 1'b0, a: wx_q, b: dt_q};
			end
			ST_M5: begin
				mac_cmd = '{en: 1'b1, clr: 1'b1, neg: 1'b0, a: wy_q, b: dt_q};
			end
			ST_M6: begin
				mac_cmd = '{en: 1'b1, clr: 1'b1, neg: 1'b0, a: MAC_A_W'(yr_q), b: dt_q};
			end
			default: begin
				mac_cmd = '0;
			end
		endcase
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
			x_q       <= '0;
			y_q       <= '0;
			heading_q <= '0;
		end else begin
			// Raise the result beat when the sequencer finishes, drop it once taken
			if (state_q == ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_axis_tuser[0] == OP_LOAD) begin
							x_q       <= s_axis_tdata[111:80];
							y_q       <= s_axis_tdata[143:112];
							heading_q <= s_axis_tdata[175:144];
							state_q   <= ST_DONE;
						end else begin
							state_q <= ST_CORDIC;
						end
					end
				end
				ST_CORDIC: begin
					if (cordic_done) begin
						state_q <= ST_M0;
					end
				end
				ST_M0: state_q <= ST_M1;
				ST_M1: state_q <= ST_M2;
				ST_M2: state_q <= ST_M3;
				ST_M3: state_q <= ST_M4;
				ST_M4: state_q <= ST_M5;
				ST_M5: begin
					x_q     <= x_q + acc_r32[POSE_W-1:0];
					state_q <= ST_M6;
				end
				ST_M6: begin
					y_q     <= y_q + acc_r32[POSE_W-1:0];
					state_q <= ST_M7;
				end
				ST_M7: begin
					heading_q <= heading_q + acc_r4[POSE_W-1:0];
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold beat operands, world velocities and the result payload
	always_ff @(posedge clk) begin
		if (cordic_start) begin
			vf_q <= s_axis_tdata[15:0];
			vl_q <= s_axis_tdata[31:16];
			yr_q <= s_axis_tdata[55:32];
			dt_q <= dt_in[DT_W-1] ? '0 : dt_in;
		end
		if (state_q == ST_M2) begin
			wx_q <= acc_r14[MAC_A_W-1:0];
		end
		if (state_q == ST_M4) begin
			wy_q <= acc_r14[MAC_A_W-1:0];
		end
		if (state_q == ST_DONE && out_free) begin
			m_data_q <= {heading_q, y_q, x_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// An integrate beat always starts the CORDIC pass
	a_integrate_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (s_axis_tuser[0] == OP_INTEGRATE) |=> state_q == ST_CORDIC)
		else $error("integrate beat did not start the CORDIC pass");

	// CORDIC completion is only seen while the sequencer waits for it
	a_cordic_done_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		cordic_done |-> state_q == ST_CORDIC)
		else $error("CORDIC finished outside its sequencer state");

	// Pose holds while idle with no beat taken
	a_pose_stable_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) && !accept |=> $stable(x_q) && $stable(y_q) && $stable(heading_q))
		else $error("pose changed while idle");

	// A result is only loaded when the output register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_axis_tready |=> m_valid_q && $stable(m_data_q))
		else $error("pending result overwritten");

endmodule
